FILE: sv/tea_pkg.sv
package tea_pkg;

    localparam int unsigned ROUNDS = 32;
    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

    // register indexes of the key port
    localparam logic [1:0] KEY_A = 2'd0;
    localparam logic [1:0] KEY_B = 2'd1;
    localparam logic [1:0] KEY_C = 2'd2;
    localparam logic [1:0] KEY_D = 2'd3;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  valid;
        logic  mode;      // 1: decrypt
        t_word left;
        t_word right;
    } t_item;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_key;

    function automatic t_word mix(input t_word w, input t_word sum,
                                  input t_word p, input t_word q);
        t_word shl;
        t_word shr;
        shl = {w[WORD_W-5:0], 4'b0000};
        shr = {5'b00000, w[WORD_W-1:5]};
        return (shl + p) ^ (w + sum) ^ (shr + q);
    endfunction

    // running sum used by round idx; only ever called with constant arguments
    function automatic t_word round_sum(input int unsigned idx, input logic decrypt);
        logic [2*WORD_W-1:0] prod;
        logic [2*WORD_W-1:0] mult;
        mult = decrypt ? 64'(ROUNDS - idx) : 64'(idx + 1);
        prod = 64'(DELTA) * mult;
        return prod[WORD_W-1:0];
    endfunction

endpackage

FILE: sv/tea_block_cipher_core.sv
// TEA cipher, 32 rounds unrolled into 64 register stages (two per round).
// Path from input acceptance to result valid on m_axis: the 64 half-round
// stages, then the output register.
// Throughput: one 64-bit block per cycle; a stalled output parks one item
// in a skid slot, then the whole pipeline holds.
// Reset (synchronous, i_rst_n low) clears all valid bits and zeroes the key.
module tea_block_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] left_in, [63:32] right_in
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] left_out, [63:32] right_out
);

    tea_pkg::t_key  r_key;
    tea_pkg::t_item w_stage [0:tea_pkg::ROUNDS];
    tea_pkg::t_item w_out;
    logic           w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tea_pkg::KEY_A: r_key.a <= i_cfg_data;
                tea_pkg::KEY_B: r_key.b <= i_cfg_data;
                tea_pkg::KEY_C: r_key.c <= i_cfg_data;
                tea_pkg::KEY_D: r_key.d <= i_cfg_data;
                default: r_key <= r_key;
            endcase
        end
    end

    assign s_axis_tready = w_en;

    assign w_stage[0].valid = s_axis_tvalid;
    assign w_stage[0].mode  = s_axis_tuser;
    assign w_stage[0].left  = s_axis_tdata[31:0];
    assign w_stage[0].right = s_axis_tdata[63:32];

    for (genvar g = 0; g < tea_pkg::ROUNDS; g++) begin : g_round
        tea_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_key     (r_key),
            .i_sum_enc (tea_pkg::round_sum(g, 1'b0)),
            .i_sum_dec (tea_pkg::round_sum(g, 1'b1)),
            .i_item    (w_stage[g]),
            .o_item    (w_stage[g+1])
        );
    end

    tea_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_stage[tea_pkg::ROUNDS]),
        .o_ready  (w_en),
        .o_item   (w_out),
        .i_tready (m_axis_tready)
    );

    assign m_axis_tvalid = w_out.valid;
    assign m_axis_tdata  = {w_out.right, w_out.left};

endmodule

FILE: sv/tea_round.sv
module tea_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tea_pkg::t_key   i_key,
    input  tea_pkg::t_word  i_sum_enc,
    input  tea_pkg::t_word  i_sum_dec,
    input  tea_pkg::t_item  i_item,
    output tea_pkg::t_item  o_item
);

    tea_pkg::t_item r_mid;
    tea_pkg::t_item n_mid;
    tea_pkg::t_item r_out;
    tea_pkg::t_item n_out;

    // first half: encrypt updates left from right, decrypt updates right from left
    always_comb begin
        n_mid = i_item;
        if (i_item.mode) begin
            n_mid.right = i_item.right
                        - tea_pkg::mix(i_item.left, i_sum_dec, i_key.c, i_key.d);
        end else begin
            n_mid.left = i_item.left
                       + tea_pkg::mix(i_item.right, i_sum_enc, i_key.a, i_key.b);
        end
    end

    // second half: the other word
    always_comb begin
        n_out = r_mid;
        if (r_mid.mode) begin
            n_out.left = r_mid.left
                       - tea_pkg::mix(r_mid.right, i_sum_dec, i_key.a, i_key.b);
        end else begin
            n_out.right = r_mid.right
                        + tea_pkg::mix(r_mid.left, i_sum_enc, i_key.c, i_key.d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_mid <= n_mid;
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

FILE: sv/tea_out_skid.sv
module tea_out_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tea_pkg::t_item  i_item,
    output logic            o_ready,
    output tea_pkg::t_item  o_item,
    input  logic            i_tready
);

    tea_pkg::t_item r_out;
    tea_pkg::t_item n_out;
    tea_pkg::t_item r_skid;
    tea_pkg::t_item n_skid;
    logic           w_take;
    logic           w_push;

    assign o_ready = !r_skid.valid;
    assign w_take  = r_out.valid && i_tready;
    // pipeline only moves while the skid slot is empty
    assign w_push  = i_item.valid && !r_skid.valid;

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        if (w_take) begin
            n_out.valid = 1'b0;
        end
        if (r_skid.valid && w_take) begin
            n_out        = r_skid;
            n_skid.valid = 1'b0;
        end else if (w_push) begin
            if (!r_out.valid || w_take) begin
                n_out = i_item;
            end else begin
                n_skid = i_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out  <= n_out;
            r_skid <= n_skid;
        end
    end

    assign o_item = r_out;

endmodule
